>>> rtl/ccpo_pkg.sv
// ---------------------------------------------------------------------------
// ccpo_pkg
// Shared types and constants for the cylinder push-out block.
// ---------------------------------------------------------------------------
package ccpo_pkg;

    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 33;

    // per-item data that rides along with the arithmetic
    typedef struct packed {
        logic               hit;
        logic               coin;
        logic               neg_x;
        logic               neg_z;
        logic [31:0]        mx;
        logic [31:0]        mz;
        logic [31:0]        r;
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } pl_t;

    // queue entry: payload plus squared horizontal distance
    typedef struct packed {
        pl_t         pl;
        logic [63:0] s;
    } qent_t;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] res;
        if (v > 35'sh0_7FFF_FFFF)
            res = 32'h7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            res = 32'h8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

endpackage

>>> rtl/ccpo_if.sv
// ---------------------------------------------------------------------------
// ccpo_if
// Valid/ready channels for cylinder pairs and push-out results.
// ---------------------------------------------------------------------------
interface ccpo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic [30:0]        a_radius;
    logic [30:0]        a_height;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [30:0]        b_radius;
    logic [30:0]        b_height;

    modport source (output valid, a_x, a_y, a_z, a_radius, a_height,
                    b_x, b_y, b_z, b_radius, b_height, input ready);
    modport sink (input valid, a_x, a_y, a_z, a_radius, a_height,
                  b_x, b_y, b_z, b_radius, b_height, output ready);
endinterface

interface ccpo_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic signed [31:0] new_b_z;

    modport source (output valid, hit, new_b_x, new_b_y, new_b_z, input ready);
    modport sink (input valid, hit, new_b_x, new_b_y, new_b_z, output ready);
endinterface

>>> rtl/ccpo_queue.sv
// ---------------------------------------------------------------------------
// ccpo_queue
// Short register FIFO between the classify front and the solve back end.
// ---------------------------------------------------------------------------
module ccpo_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ccpo_pkg::qent_t   wdata,
    input  logic              pop,
    output ccpo_pkg::qent_t   rdata,
    output logic              full,
    output logic              empty
);

    ccpo_pkg::qent_t                mem_reg [ccpo_pkg::Q_DEPTH];
    logic [ccpo_pkg::Q_AW-1:0]      wp_reg;
    logic [ccpo_pkg::Q_AW-1:0]      rp_reg;
    logic [ccpo_pkg::Q_AW:0]        cnt_reg;
    logic [ccpo_pkg::Q_AW:0]        cnt_next;

    assign full  = (cnt_reg == (ccpo_pkg::Q_AW+1)'(ccpo_pkg::Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (ccpo_pkg::Q_AW+1)'(ccpo_pkg::Q_DEPTH))
        else $error("queue count past depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !empty)
        else $error("queue empty after push");

endmodule

>>> rtl/ccpo_sqrt.sv
// ---------------------------------------------------------------------------
// ccpo_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module ccpo_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] s,
    output logic [31:0] root
);

    localparam int N = ccpo_pkg::SQ_STAGES;

    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] s_reg    [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [33:0] rem_prev;
        logic [31:0] root_prev;
        logic [63:0] s_prev;
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign s_prev    = s;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign s_prev    = s_reg[k-1];
        end

        assign cur   = {rem_prev, s_prev[63-2*k -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? 34'(cur - trial) : cur[33:0];
                root_reg[k] <= {root_prev[30:0], ge};
                s_reg[k]    <= s_prev;
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> rtl/ccpo_div.sv
// ---------------------------------------------------------------------------
// ccpo_div
// Pipelined restoring divider, 64 by 32 bits with a 33 bit quotient.
// The quotient must fit in 33 bits (num < den * 2^33).
// ---------------------------------------------------------------------------
module ccpo_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [32:0] quo
);

    localparam int N = ccpo_pkg::DIV_STAGES;

    logic [31:0] rem_reg [N];
    logic [32:0] quo_reg [N];
    logic [63:0] num_reg [N];
    logic [31:0] den_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [31:0] rem_prev;
        logic [32:0] quo_prev;
        logic [63:0] num_prev;
        logic [31:0] den_prev;
        logic [32:0] cur;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_prev = {1'b0, num[63:33]};
            assign quo_prev = '0;
            assign num_prev = num;
            assign den_prev = den;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[i-1];
            assign quo_prev = quo_reg[i-1];
            assign num_prev = num_reg[i-1];
            assign den_prev = den_reg[i-1];
        end

        assign cur = {rem_prev, num_prev[32-i]};
        assign ge  = (cur >= {1'b0, den_prev});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? 32'(cur - {1'b0, den_prev}) : cur[31:0];
                quo_reg[i] <= {quo_prev[31:0], ge};
                num_reg[i] <= num_prev;
                den_reg[i] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[N-1];

endmodule

>>> rtl/ccpo_front.sv
// ---------------------------------------------------------------------------
// ccpo_front
// Accepts cylinder pairs, runs the vertical and radial overlap tests and
// hands classified items to the queue.
// ---------------------------------------------------------------------------
module ccpo_front (
    input  logic              clk,
    input  logic              rst_n,
    ccpo_in_if.sink           cyl,
    input  logic              q_full,
    output logic              q_push,
    output ccpo_pkg::qent_t   q_data
);

    logic en;

    // stage 1: differences and vertical test
    logic signed [33:0] ay_e, by_e, ah_e, bh_e;
    logic               vmiss;

    logic               f1_v_reg;
    logic               f1_vhit_reg;
    logic signed [32:0] f1_vx_reg, f1_vz_reg;
    logic [31:0]        f1_r_reg;
    logic signed [31:0] f1_ax_reg, f1_az_reg, f1_bx_reg, f1_by_reg, f1_bz_reg;

    // stage 2: squares
    logic [32:0]        vx_abs, vz_abs;
    logic [31:0]        mx, mz;
    logic [63:0]        sx_c, sz_c, r2_c;

    logic               f2_v_reg;
    logic               f2_big_reg;
    logic [63:0]        f2_sx_reg, f2_sz_reg, f2_r2_reg;
    ccpo_pkg::pl_t      f2_pl_reg;

    logic [64:0]        s65;

    assign en        = !f2_v_reg || !q_full;
    assign cyl.ready = en;

    assign ay_e  = {{2{cyl.a_y[31]}}, cyl.a_y};
    assign by_e  = {{2{cyl.b_y[31]}}, cyl.b_y};
    assign ah_e  = {3'b000, cyl.a_height};
    assign bh_e  = {3'b000, cyl.b_height};
    assign vmiss = (ay_e > by_e + bh_e) || (ay_e + ah_e < by_e);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= cyl.valid;
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_vhit_reg <= !vmiss;
            f1_vx_reg   <= {cyl.b_x[31], cyl.b_x} - {cyl.a_x[31], cyl.a_x};
            f1_vz_reg   <= {cyl.b_z[31], cyl.b_z} - {cyl.a_z[31], cyl.a_z};
            f1_r_reg    <= {1'b0, cyl.a_radius} + {1'b0, cyl.b_radius};
            f1_ax_reg   <= cyl.a_x;
            f1_az_reg   <= cyl.a_z;
            f1_bx_reg   <= cyl.b_x;
            f1_by_reg   <= cyl.b_y;
            f1_bz_reg   <= cyl.b_z;
        end
    end

    assign vx_abs = f1_vx_reg[32] ? 33'(-f1_vx_reg) : f1_vx_reg;
    assign vz_abs = f1_vz_reg[32] ? 33'(-f1_vz_reg) : f1_vz_reg;
    assign mx     = vx_abs[31:0];
    assign mz     = vz_abs[31:0];
    assign sx_c   = mx * mx;
    assign sz_c   = mz * mz;
    assign r2_c   = f1_r_reg * f1_r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_big_reg      <= (mx > f1_r_reg) || (mz > f1_r_reg);
            f2_sx_reg       <= sx_c;
            f2_sz_reg       <= sz_c;
            f2_r2_reg       <= r2_c;
            f2_pl_reg.hit   <= f1_vhit_reg;
            f2_pl_reg.coin  <= 1'b0;
            f2_pl_reg.neg_x <= f1_vx_reg[32];
            f2_pl_reg.neg_z <= f1_vz_reg[32];
            f2_pl_reg.mx    <= mx;
            f2_pl_reg.mz    <= mz;
            f2_pl_reg.r     <= f1_r_reg;
            f2_pl_reg.ax    <= f1_ax_reg;
            f2_pl_reg.az    <= f1_az_reg;
            f2_pl_reg.bx    <= f1_bx_reg;
            f2_pl_reg.by    <= f1_by_reg;
            f2_pl_reg.bz    <= f1_bz_reg;
        end
    end

    // stage 3 (combinational into the queue): radial test
    assign s65 = {1'b0, f2_sx_reg} + {1'b0, f2_sz_reg};

    always_comb
    begin
        q_data         = '0;
        q_data.pl      = f2_pl_reg;
        q_data.pl.hit  = f2_pl_reg.hit && !f2_big_reg && (s65 <= {1'b0, f2_r2_reg});
        q_data.pl.coin = (s65 == '0);
        q_data.s       = s65[63:0];
    end

    assign q_push = f2_v_reg && !q_full;

endmodule

>>> rtl/ccpo_back.sv
// ---------------------------------------------------------------------------
// ccpo_back
// Square root, offset scaling, rounding division and saturation; drives
// the result channel from its output register.
// ---------------------------------------------------------------------------
module ccpo_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ccpo_pkg::qent_t   q_data,
    input  logic              q_empty,
    output logic              q_pop,
    ccpo_out_if.source        res
);

    localparam int NS = ccpo_pkg::SQ_STAGES;
    localparam int ND = ccpo_pkg::DIV_STAGES;

    logic               en;
    logic               out_v_reg;

    logic [NS-1:0]      sv_reg;
    ccpo_pkg::pl_t      spl_reg [NS];
    logic [31:0]        d;

    logic               m_v_reg;
    ccpo_pkg::pl_t      m_pl_reg;
    logic [63:0]        m_nx_reg, m_nz_reg;
    logic [31:0]        m_d_reg;
    logic [63:0]        px_c, pz_c;

    logic [ND-1:0]      dv_reg;
    ccpo_pkg::pl_t      dpl_reg [ND];
    logic [32:0]        qx, qz;

    ccpo_pkg::pl_t      fp;
    logic signed [34:0] off_x, off_z, sum_x, sum_z;
    logic signed [31:0] nx_next, nz_next;

    assign en    = !out_v_reg || res.ready;
    assign q_pop = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg    <= '0;
            m_v_reg   <= 1'b0;
            dv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg    <= {sv_reg[NS-2:0], q_pop};
            m_v_reg   <= sv_reg[NS-1];
            dv_reg    <= {dv_reg[ND-2:0], m_v_reg};
            out_v_reg <= dv_reg[ND-1];
        end
    end

    // floor(sqrt(s))
    ccpo_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .s    (q_data.s),
        .root (d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spl_reg[0] <= q_data.pl;
            for (int k = 1; k < NS; k++)
                spl_reg[k] <= spl_reg[k-1];
        end
    end

    // rounding numerators |v|*r + d/2
    assign px_c = spl_reg[NS-1].mx * spl_reg[NS-1].r;
    assign pz_c = spl_reg[NS-1].mz * spl_reg[NS-1].r;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_pl_reg <= spl_reg[NS-1];
            m_nx_reg <= px_c + {33'b0, d[31:1]};
            m_nz_reg <= pz_c + {33'b0, d[31:1]};
            m_d_reg  <= d;
        end
    end

    ccpo_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (m_nx_reg),
        .den (m_d_reg),
        .quo (qx)
    );

    ccpo_div u_div_z (
        .clk (clk),
        .en  (en),
        .num (m_nz_reg),
        .den (m_d_reg),
        .quo (qz)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpl_reg[0] <= m_pl_reg;
            for (int k = 1; k < ND; k++)
                dpl_reg[k] <= dpl_reg[k-1];
        end
    end

    assign fp    = dpl_reg[ND-1];
    assign off_x = fp.neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    assign off_z = fp.neg_z ? -$signed({2'b00, qz}) : $signed({2'b00, qz});

    always_comb
    begin
        if (fp.coin)
        begin
            // coincident axes: push along +x
            sum_x = {{3{fp.ax[31]}}, fp.ax} + $signed({3'b000, fp.r});
            sum_z = {{3{fp.az[31]}}, fp.az};
        end
        else
        begin
            sum_x = {{3{fp.ax[31]}}, fp.ax} + off_x;
            sum_z = {{3{fp.az[31]}}, fp.az} + off_z;
        end
        if (fp.hit)
        begin
            nx_next = ccpo_pkg::sat32(sum_x);
            nz_next = ccpo_pkg::sat32(sum_z);
        end
        else
        begin
            nx_next = fp.bx;
            nz_next = fp.bz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.hit     <= fp.hit;
            res.new_b_x <= nx_next;
            res.new_b_y <= fp.by;
            res.new_b_z <= nz_next;
        end
    end

    assign res.valid = out_v_reg;

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_reg[ND-1]) |=> out_v_reg)
        else $error("finished item lost before output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !res.ready) |=> (sv_reg == $past(sv_reg)))
        else $error("pipeline moved while output stalled");
    a_pop_gate: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> en)
        else $error("queue popped while back end stalled");

endmodule

>>> rtl/cylinder_cylinder_push_out_top.sv
// ---------------------------------------------------------------------------
// cylinder_cylinder_push_out_top
// Upright cylinder pair collision test with push-out of cylinder B.
// ---------------------------------------------------------------------------
// Accepts one cylinder pair per cycle while the queue is not full and returns
// exactly one result per item, in order. Items pass two classify stages and
// the queue on the front, then 32 square-root stages, one multiply stage, 33
// divider stages and the output register. The pipelined square root and the
// two pipelined dividers set the depth; throughput is one item per cycle
// when the result side is ready. A stall on the result side freezes the back
// end; the four-entry queue lets the front keep accepting until it fills.
module cylinder_cylinder_push_out_top (
    input  logic        clk,
    input  logic        rst_n,
    ccpo_in_if.sink     cyl,
    ccpo_out_if.source  res
);

    logic            q_push, q_pop, q_full, q_empty;
    ccpo_pkg::qent_t q_wdata, q_rdata;

    ccpo_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cyl    (cyl),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    ccpo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    ccpo_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule
